/* rtl/ctsch_pkg.sv */
// Package for the callback timer scheduler.
// Holds field widths, status and kind codes, the slot entry type and defaults.
// No dependencies.
package ctsch_pkg;

   // Field widths of the request and response words.
   localparam int KIND_W     = 2;
   localparam int TIME_W     = 64;
   localparam int PERIOD_W   = 32;
   localparam int TAG_W      = 32;
   localparam int HANDLE_W   = 4;
   localparam int STATUS_W   = 3;

   // Default sizes handed to the top level.
   localparam int SLOTS_DEFAULT          = 16;
   localparam int FIRES_PER_TICK_DEFAULT = 16;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED   = 3'd0,
      ST_REMOVED = 3'd1,
      ST_INVALID = 3'd2,
      ST_FULL    = 3'd3,
      ST_FIRED   = 3'd4
   } status_type;

   // One timer slot as kept in the slot memory.
   typedef struct packed {
      logic                rpt;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   deadline;
      logic [TAG_W-1:0]    tag;
   } entry_type;

endpackage

/* rtl/ctsch_req_if.sv */
// Request channel of the callback timer scheduler: valid/ready plus the request word.
// Depends on ctsch_pkg for field widths.
interface ctsch_req_if;
   logic                             valid;
   logic                             ready;
   logic [ctsch_pkg::KIND_W-1:0]     kind;
   logic [ctsch_pkg::TIME_W-1:0]     now;
   logic [ctsch_pkg::PERIOD_W-1:0]   interval;
   logic                             repeat_req;
   logic [ctsch_pkg::TAG_W-1:0]      user_tag;
   logic [ctsch_pkg::HANDLE_W-1:0]   handle;

   modport source (output valid, kind, now, interval, repeat_req, user_tag, handle,
                   input ready);
   modport sink   (input valid, kind, now, interval, repeat_req, user_tag, handle,
                   output ready);
endinterface

/* rtl/ctsch_rsp_if.sv */
// Response channel of the callback timer scheduler: valid/ready plus the response word.
// Depends on ctsch_pkg for field widths.
interface ctsch_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ctsch_pkg::STATUS_W-1:0]   status;
   logic [ctsch_pkg::HANDLE_W-1:0]   slot;
   logic [ctsch_pkg::TAG_W-1:0]      tag;
   logic                             last;

   modport source (output valid, status, slot, tag, last, input ready);
   modport sink   (input valid, status, slot, tag, last, output ready);
endinterface

/* rtl/ctsch_alu.sv */
// Shared arithmetic unit: saturating 64-bit deadline adder and 64-bit less-than compare.
// Depends on ctsch_pkg.
module ctsch_alu (
   input  logic [ctsch_pkg::TIME_W-1:0]   add_a,
   input  logic [ctsch_pkg::PERIOD_W-1:0] add_b,
   output logic [ctsch_pkg::TIME_W-1:0]   sum,
   input  logic [ctsch_pkg::TIME_W-1:0]   cmp_a,
   input  logic [ctsch_pkg::TIME_W-1:0]   cmp_b,
   output logic                           less
);
   import ctsch_pkg::*;

   logic [TIME_W:0] full_sum;

   // A carry out means the deadline passed the top of the time range: pin it there.
   assign full_sum = {1'b0, add_a} + {{(TIME_W - PERIOD_W + 1){1'b0}}, add_b};
   assign sum      = full_sum[TIME_W] ? {TIME_W{1'b1}} : full_sum[TIME_W-1:0];

   // Unsigned compare used by the deadline scan.
   assign less = cmp_a < cmp_b;
endmodule

/* rtl/ctsch_store.sv */
// Slot memory of the callback timer scheduler: one write port, one registered read port.
// Depends on ctsch_pkg for the entry type.
module ctsch_store #(
   parameter int SLOTS = ctsch_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(SLOTS)-1:0]      wr_addr,
   input  ctsch_pkg::entry_type          wr_data,
   input  logic [$clog2(SLOTS)-1:0]      rd_addr,
   output ctsch_pkg::entry_type          rd_data
);
   import ctsch_pkg::*;

   entry_type mem [SLOTS];

   // Write and registered read; slots that were never written can also be read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/callback_timer_scheduler.sv */
// Callback timer scheduler: a table of SLOTS timers. An add word takes the lowest free
// slot (one live bit checked per cycle) and answers with its handle or with table full.
// A remove word answers with the tag or invalid handle. A tick word fires expired timers
// earliest deadline first, lowest slot on ties, at most FIRES_PER_TICK of them; every
// fire costs one pass over the slot memory through the single read port and the shared
// 64-bit comparator. Below the cap a last pass finds nothing left. The held fire goes
// out as the final word; a tick that fires nothing sends no word. A stalled response
// channel holds the add, remove or tick until the output register is free.
// The request side is ready only between words; a finished response waits in the output
// register while the next word is taken.
module callback_timer_scheduler #(
   parameter int SLOTS          = ctsch_pkg::SLOTS_DEFAULT,
   parameter int FIRES_PER_TICK = ctsch_pkg::FIRES_PER_TICK_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ctsch_req_if.sink   req_chan,
   ctsch_rsp_if.source rsp_chan
);
   import ctsch_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(FIRES_PER_TICK + 1);
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0]  LAST_FIRE = CNT_W'(FIRES_PER_TICK - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_FIND,
      S_ADD_WRITE,
      S_RM_READ,
      S_RM_RESP,
      S_TICK_SCAN,
      S_TICK_DRAIN,
      S_TICK_DECIDE,
      S_TICK_FLUSH
   } state_type;

   state_type             state_ff, state_in;
   logic [SLOTS-1:0]      live_ff, live_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [PERIOD_W-1:0]   interval_ff, interval_in;
   logic                  rpt_ff, rpt_in;
   logic [TAG_W-1:0]      tag_ff, tag_in;
   logic [HANDLE_W-1:0]   handle_ff, handle_in;
   logic                  rm_ok_ff, rm_ok_in;
   logic [TIME_W-1:0]     limit_ff, limit_in;
   logic                  best_found_ff, best_found_in;
   logic [SLOT_W-1:0]     best_idx_ff, best_idx_in;
   entry_type             best_ff, best_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [SLOT_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic [TAG_W-1:0]      pend_tag_ff, pend_tag_in;
   logic [CNT_W-1:0]      fire_cnt_ff, fire_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [TAG_W-1:0]      rsp_tag_ff, rsp_tag_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic [SLOT_W-1:0]     req_idx;
   logic [SLOT_W-1:0]     handle_idx;
   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_waddr;
   entry_type             mem_wdata;
   logic [SLOT_W-1:0]     mem_raddr;
   entry_type             mem_rdata;
   logic [TIME_W-1:0]     add_a;
   logic [PERIOD_W-1:0]   add_b;
   logic [TIME_W-1:0]     add_sum;
   logic                  dl_less;
   logic                  cand;

   // Slot memory and the shared adder/comparator.
   ctsch_store #(.SLOTS(SLOTS)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   ctsch_alu u_alu (
      .add_a (add_a),
      .add_b (add_b),
      .sum   (add_sum),
      .cmp_a (mem_rdata.deadline),
      .cmp_b (limit_ff),
      .less  (dl_less)
   );

   // Adder operands: arming a new timer or rearming the one that just fired.
   assign add_a = (state_ff == S_ADD_WRITE) ? now_ff : best_ff.deadline;
   assign add_b = (state_ff == S_ADD_WRITE) ? interval_ff : best_ff.period;

   assign req_idx    = SLOT_W'(req_chan.handle);
   assign handle_idx = SLOT_W'(handle_ff);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   // A scanned slot beats the current best when it is live and strictly earlier than
   // the limit, which is the tick time until a best is found and its deadline after.
   assign cand = cmp_valid_ff && live_ff[cmp_idx_ff] && dl_less;

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      live_in       = live_ff;
      idx_in        = idx_ff;
      now_in        = now_ff;
      interval_in   = interval_ff;
      rpt_in        = rpt_ff;
      tag_in        = tag_ff;
      handle_in     = handle_ff;
      rm_ok_in      = rm_ok_ff;
      limit_in      = limit_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      fire_cnt_in   = fire_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = best_ff;
      mem_raddr     = idx_ff;

      // Compare stage of the scan, one slot per cycle.
      if (cand) begin
         best_found_in = 1'b1;
         best_idx_in   = cmp_idx_ff;
         best_in       = mem_rdata;
         limit_in      = mem_rdata.deadline;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               now_in      = req_chan.now;
               interval_in = (req_chan.interval == '0) ? PERIOD_W'(1) : req_chan.interval;
               rpt_in      = req_chan.repeat_req;
               tag_in      = req_chan.user_tag;
               handle_in   = req_chan.handle;
               idx_in      = '0;
               case (req_chan.kind)
                  KIND_ADD: begin
                     state_in = S_ADD_FIND;
                  end
                  KIND_REMOVE: begin
                     rm_ok_in = (32'(req_chan.handle) < SLOTS) && live_ff[req_idx];
                     state_in = S_RM_READ;
                  end
                  KIND_TICK: begin
                     limit_in      = req_chan.now;
                     best_found_in = 1'b0;
                     pend_valid_in = 1'b0;
                     fire_cnt_in   = '0;
                     state_in      = S_TICK_SCAN;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Look for the lowest free slot.
         S_ADD_FIND: begin
            if (!live_ff[idx_ff]) begin
               state_in = S_ADD_WRITE;
            end else if (idx_ff == LAST_IDX) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FULL;
                  rsp_slot_in   = '0;
                  rsp_tag_in    = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end

         // Arm the free slot and report its handle.
         S_ADD_WRITE: begin
            if (out_free) begin
               mem_we             = 1'b1;
               mem_waddr          = idx_ff;
               mem_wdata.rpt      = rpt_ff;
               mem_wdata.period   = interval_ff;
               mem_wdata.deadline = add_sum;
               mem_wdata.tag      = tag_ff;
               live_in[idx_ff]    = 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_status_in      = ST_ADDED;
               rsp_slot_in        = HANDLE_W'(idx_ff);
               rsp_tag_in         = tag_ff;
               rsp_last_in        = 1'b1;
               state_in           = S_IDLE;
            end
         end

         S_RM_READ: begin
            mem_raddr = handle_idx;
            state_in  = S_RM_RESP;
         end

         // Keep the read address on the handle so the tag holds while the output waits.
         S_RM_RESP: begin
            mem_raddr = handle_idx;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = handle_ff;
               rsp_last_in  = 1'b1;
               if (rm_ok_ff) begin
                  live_in[handle_idx] = 1'b0;
                  rsp_status_in       = ST_REMOVED;
                  rsp_tag_in          = mem_rdata.tag;
               end else begin
                  rsp_status_in = ST_INVALID;
                  rsp_tag_in    = '0;
               end
               state_in = S_IDLE;
            end
         end

         // Issue one slot read per cycle into the compare stage.
         S_TICK_SCAN: begin
            cmp_valid_in = 1'b1;
            cmp_idx_in   = idx_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = S_TICK_DRAIN;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end

         S_TICK_DRAIN: begin
            state_in = S_TICK_DECIDE;
         end

         // Fire the earliest expired timer if one was found; the previous fire goes out as a non-final word.
         S_TICK_DECIDE: begin
            if (!best_found_ff) begin
               state_in = S_TICK_FLUSH;
            end else if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FIRED;
                  rsp_slot_in   = HANDLE_W'(pend_slot_ff);
                  rsp_tag_in    = pend_tag_ff;
                  rsp_last_in   = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = best_idx_ff;
               pend_tag_in   = best_ff.tag;
               if (best_ff.rpt) begin
                  mem_we             = 1'b1;
                  mem_waddr          = best_idx_ff;
                  mem_wdata          = best_ff;
                  mem_wdata.deadline = add_sum;
               end else begin
                  live_in[best_idx_ff] = 1'b0;
               end
               fire_cnt_in   = fire_cnt_ff + CNT_W'(1);
               best_found_in = 1'b0;
               limit_in      = now_ff;
               idx_in        = '0;
               state_in      = (fire_cnt_ff == LAST_FIRE) ? S_TICK_FLUSH : S_TICK_SCAN;
            end
         end

         // Send the held fire, if there is one, as the final word of the tick.
         S_TICK_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FIRED;
               rsp_slot_in   = HANDLE_W'(pend_slot_ff);
               rsp_tag_in    = pend_tag_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, control and payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      now_ff        <= now_in;
      interval_ff   <= interval_in;
      rpt_ff        <= rpt_in;
      tag_ff        <= tag_in;
      handle_ff     <= handle_in;
      rm_ok_ff      <= rm_ok_in;
      limit_ff      <= limit_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      cmp_idx_ff    <= cmp_idx_in;
      pend_slot_ff  <= pend_slot_in;
      pend_tag_ff   <= pend_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         live_ff       <= '0;
         best_found_ff <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         best_found_ff <= best_found_in;
         cmp_valid_ff  <= cmp_valid_in;
         pend_valid_ff <= pend_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Channel outputs.
   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.slot   = rsp_slot_ff;
   assign rsp_chan.tag    = rsp_tag_ff;
   assign rsp_chan.last   = rsp_last_ff;

   // A tick never fires more timers than the cap.
   a_fire_cap: assert property (@(posedge clock) disable iff (reset)
      32'(fire_cnt_ff) <= FIRES_PER_TICK)
      else $error("fire count passed the per-tick cap");

   // An add only ever arms a slot that is free.
   a_add_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD_WRITE) |-> !live_ff[idx_ff])
      else $error("add is about to overwrite a live slot");

   // No fire is left held once the block takes a new word.
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !pend_valid_ff)
      else $error("held fire left behind at end of tick");

   // The scan limit tracks the deadline of the best candidate.
   a_best_limit: assert property (@(posedge clock) disable iff (reset)
      best_found_ff |-> (best_ff.deadline == limit_ff))
      else $error("scan limit does not match best deadline");
endmodule
